/* design/tcw_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

    localparam int COLS         = 80;
    localparam int ROWS         = 25;
    localparam int CELLS        = COLS * ROWS;
    localparam int SCROLL_CELLS = COLS * (ROWS - 1);
    localparam int COL_W        = $clog2(COLS);
    localparam int ROW_W        = $clog2(ROWS);
    localparam int ADDR_W       = $clog2(CELLS);

    localparam logic [7:0] RESET_BLANK = 8'h07;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_TILDE    = 8'd126;
    localparam logic [7:0] CH_LF       = 8'd10;
    localparam logic [7:0] CH_CR       = 8'd13;
    localparam logic [7:0] CH_BS       = 8'd8;

    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_SET   = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_READ  = 2'd3;

    localparam logic [1:0] SWP_INIT   = 2'd0;
    localparam logic [1:0] SWP_BLANK  = 2'd1;
    localparam logic [1:0] SWP_SCROLL = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
        logic [3:0] fore_color;
        logic [3:0] back_color;
        logic [7:0] col_in;
        logic [7:0] row_in;
    } tcw_req_t;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_offset;
        logic [7:0]  read_char;
        logic [7:0]  read_attr;
        logic        scrolled;
    } tcw_rsp_t;

    typedef struct packed {
        logic       capture;
        logic       exec;
        logic       sweep;
        logic [1:0] sweep_mode;
    } tcw_cmd_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic       need_scroll;
        logic       sweep_last;
    } tcw_stat_t;

endpackage

`default_nettype wire

/* design/tcw_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_datapath
// Cell store, cursor, blank color register, sweep counter and write stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_datapath
    import tcw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire tcw_req_t  req,
    input  wire logic      cfg_we,
    input  wire logic [7:0] cfg_data,
    input  wire tcw_cmd_t  cmd,
    output tcw_stat_t      stat,
    output tcw_rsp_t       rsp
);

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLS);
    localparam logic [ADDR_W-1:0] SCROLL_A  = ADDR_W'(SCROLL_CELLS);
    localparam logic [ADDR_W-1:0] LAST_A    = ADDR_W'(CELLS - 1);

    logic [15:0] mem [0:CELLS-1];

    tcw_req_t          req_reg, req_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [7:0]        blank_reg, blank_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              wr_en_reg, wr_en_next;
    logic              wr_copy_reg, wr_copy_next;
    logic [ADDR_W-1:0] wr_addr_reg, wr_addr_next;
    logic [15:0]       wr_data_reg, wr_data_next;
    logic              scrolled_reg, scrolled_next;
    logic              rd_flag_reg, rd_flag_next;
    logic [15:0]       rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;

    logic [ADDR_W-1:0] cur_off;
    logic [COL_W-1:0]  clamp_col;
    logic [ROW_W-1:0]  clamp_row;
    logic [ADDR_W-1:0] clamp_off;
    logic              printable;
    logic              col_last;
    logic              row_last;
    logic              need_scroll;

    assign cur_off   = ADDR_W'(row_reg) * COLS_A + ADDR_W'(col_reg);
    assign clamp_col = (req_reg.col_in >= 8'(COLS)) ? COL_LAST : COL_W'(req_reg.col_in);
    assign clamp_row = (req_reg.row_in >= 8'(ROWS)) ? ROW_LAST : ROW_W'(req_reg.row_in);
    assign clamp_off = ADDR_W'(clamp_row) * COLS_A + ADDR_W'(clamp_col);
    assign printable = (req_reg.char_code >= CH_SPACE) && (req_reg.char_code <= CH_TILDE);
    assign col_last  = (col_reg == COL_LAST);
    assign row_last  = (row_reg == ROW_LAST);
    assign need_scroll = (req_reg.req_type == REQ_PUT) && row_last &&
                         ((req_reg.char_code == CH_LF) || (printable && col_last));

    assign stat.req_type    = req_reg.req_type;
    assign stat.need_scroll = need_scroll;
    assign stat.sweep_last  = (cnt_reg == LAST_A);

    always_comb
    begin
        req_next      = req_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        blank_next    = cfg_we ? cfg_data : blank_reg;
        cnt_next      = cnt_reg;
        wr_en_next    = 1'b0;
        wr_copy_next  = 1'b0;
        wr_addr_next  = wr_addr_reg;
        wr_data_next  = wr_data_reg;
        scrolled_next = scrolled_reg;
        rd_flag_next  = rd_flag_reg;
        rd_addr       = cur_off;

        if (cmd.capture)
        begin
            req_next = req;
        end

        if (cmd.exec)
        begin
            cnt_next      = '0;
            scrolled_next = need_scroll;
            rd_flag_next  = (req_reg.req_type == REQ_READ);
            unique case (req_reg.req_type)
                REQ_PUT:
                begin
                    priority if (req_reg.char_code == CH_LF)
                    begin
                        col_next = '0;
                        if (!row_last)
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else if (req_reg.char_code == CH_CR)
                    begin
                        col_next = '0;
                    end
                    else if (req_reg.char_code == CH_BS)
                    begin
                        if (col_reg != '0)
                        begin
                            col_next     = col_reg - 1'b1;
                            wr_en_next   = 1'b1;
                            wr_addr_next = cur_off - 1'b1;
                            wr_data_next = {blank_reg, CH_SPACE};
                        end
                    end
                    else if (printable)
                    begin
                        wr_en_next   = 1'b1;
                        wr_addr_next = cur_off;
                        wr_data_next = {req_reg.back_color, req_reg.fore_color,
                                        req_reg.char_code};
                        if (col_last)
                        begin
                            col_next = '0;
                            if (!row_last)
                            begin
                                row_next = row_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg;
                    end
                end
                REQ_SET:
                begin
                    col_next = clamp_col;
                    row_next = clamp_row;
                end
                REQ_CLEAR:
                begin
                    col_next = '0;
                    row_next = '0;
                end
                REQ_READ:
                begin
                    rd_addr = clamp_off;
                end
                default:
                begin
                    rd_addr = cur_off;
                end
            endcase
        end

        if (cmd.sweep)
        begin
            cnt_next     = cnt_reg + 1'b1;
            wr_en_next   = 1'b1;
            wr_addr_next = cnt_reg;
            if ((cmd.sweep_mode == SWP_SCROLL) && (cnt_reg < SCROLL_A))
            begin
                rd_addr      = cnt_reg + COLS_A;
                wr_copy_next = 1'b1;
            end
            else if (cmd.sweep_mode == SWP_INIT)
            begin
                wr_data_next = {RESET_BLANK, CH_SPACE};
            end
            else
            begin
                wr_data_next = {blank_reg, CH_SPACE};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            blank_reg <= RESET_BLANK;
            cnt_reg   <= '0;
            wr_en_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            blank_reg <= blank_next;
            cnt_reg   <= cnt_next;
            wr_en_reg <= wr_en_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        wr_copy_reg  <= wr_copy_next;
        wr_addr_reg  <= wr_addr_next;
        wr_data_reg  <= wr_data_next;
        scrolled_reg <= scrolled_next;
        rd_flag_reg  <= rd_flag_next;
    end

    // cell store: one write, one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en_reg)
        begin
            mem[wr_addr_reg] <= wr_copy_reg ? rd_data_reg : wr_data_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rsp.cursor_col    = 7'(col_reg);
    assign rsp.cursor_row    = 5'(row_reg);
    assign rsp.cursor_offset = 11'(cur_off);
    assign rsp.read_char     = rd_flag_reg ? rd_data_reg[7:0] : 8'd0;
    assign rsp.read_attr     = rd_flag_reg ? rd_data_reg[15:8] : 8'd0;
    assign rsp.scrolled      = scrolled_reg;

endmodule

`default_nettype wire

/* design/tcw_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: reset fill, request execute, clear/scroll sweep, response.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    output logic           busy,
    output logic           done,
    input  wire tcw_stat_t stat,
    output tcw_cmd_t       cmd
);

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_SWEEP = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.sweep_mode = SWP_INIT;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.sweep      = 1'b1;
                cmd.sweep_mode = SWP_INIT;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if ((stat.req_type == REQ_CLEAR) || stat.need_scroll)
                begin
                    state_next = ST_SWEEP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SWEEP:
            begin
                cmd.sweep      = 1'b1;
                cmd.sweep_mode = (stat.req_type == REQ_CLEAR) ? SWP_BLANK : SWP_SCROLL;
                if (stat.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_EXEC))
        else $error("accepted word did not enter execute");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> (!done && !busy))
        else $error("response strobe not followed by idle");

    a_exec_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> $past(state_reg == ST_IDLE && start))
        else $error("execute without an accepted word");

    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.exec && cmd.sweep) && !(cmd.capture && busy))
        else $error("conflicting datapath commands");

endmodule

`default_nettype wire

/* design/text_console_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine over a COLS x ROWS character/attribute store.
// ----------------------------------------------------------------------------
// Sequence: accept, execute, then result strobe for put/set/read words; clear
//   and scrolling puts sweep every cell of the store first, one cell per cycle.
// Next word is accepted in the cycle after the strobe.
// Reset: busy while the store is filled with blanks; results are never
//   stalled by the receiver.
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output logic            busy,
    input  wire tcw_req_t   req,
    output logic            done,
    output tcw_rsp_t        rsp,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_data
);

    tcw_cmd_t  cmd;
    tcw_stat_t stat;

    tcw_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .stat  (stat),
        .cmd   (cmd)
    );

    tcw_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

/* dv/tb_text_console_writer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking bench for the text console writer. A directed table covers
// cursor clamping, backspace, wrap, scroll, ignored codes and clear; random
// words with random gaps follow under several blank colors. Every result
// word is checked field by field against its table entry or a behavioral console model.
// ----------------------------------------------------------------------------

module tb_text_console_writer;
    import tcw_pkg::*;

    typedef struct {
        tcw_req_t word;
        bit       typed;
        tcw_rsp_t want;
    } dir_row_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    tcw_req_t   req;
    logic       done;
    tcw_rsp_t   rsp;
    logic       cfg_we;
    logic [7:0] cfg_data;

    logic [15:0] model_cells [CELLS];
    int          model_col;
    int          model_row;
    logic [7:0]  model_blank;

    tcw_rsp_t    due_rsp_q [$];
    dir_row_t    dir_table [$];
    int          err_count;

    text_console_writer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .done     (done),
        .rsp      (rsp),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("tb_text_console_writer NOT OK");
        $finish;
    end

    task automatic report_mismatch(input string field, input int got, input int want);
        err_count++;
        $display("%0t: %s got %0d expected %0d", $time, field, got, want);
    endtask

    function automatic tcw_req_t mk_req(logic [1:0] kind, int ch, int fg, int bg, int col,
                                        int row);
        tcw_req_t w;
        w.req_type   = kind;
        w.char_code  = ch[7:0];
        w.fore_color = fg[3:0];
        w.back_color = bg[3:0];
        w.col_in     = col[7:0];
        w.row_in     = row[7:0];
        return w;
    endfunction

    function automatic tcw_rsp_t mk_rsp(int col, int row, int off, int ch, int attr, bit scr);
        tcw_rsp_t r;
        r.cursor_col    = col[6:0];
        r.cursor_row    = row[4:0];
        r.cursor_offset = off[10:0];
        r.read_char     = ch[7:0];
        r.read_attr     = attr[7:0];
        r.scrolled      = scr;
        return r;
    endfunction

    function automatic void fill_screen();
        for (int i = 0; i < CELLS; i++)
            model_cells[i] = {model_blank, CH_SPACE};
    endfunction

    function automatic bit feed_line();
        model_col = 0;
        model_row++;
        if (model_row < ROWS)
            return 1'b0;
        for (int i = 0; i < SCROLL_CELLS; i++)
            model_cells[i] = model_cells[i + COLS];
        for (int i = 0; i < COLS; i++)
            model_cells[SCROLL_CELLS + i] = {model_blank, CH_SPACE};
        model_row = ROWS - 1;
        return 1'b1;
    endfunction

    // advance the console state by one word and return the expected result word
    function automatic tcw_rsp_t console_apply(tcw_req_t w);
        tcw_rsp_t    r;
        int          c;
        int          rw;
        logic [15:0] cell_word;
        r = '0;
        c = (w.col_in >= COLS) ? COLS - 1 : int'(w.col_in);
        rw = (w.row_in >= ROWS) ? ROWS - 1 : int'(w.row_in);
        case (w.req_type)
            REQ_PUT:
            begin
                if (w.char_code == CH_LF)
                    r.scrolled = feed_line();
                else if (w.char_code == CH_CR)
                    model_col = 0;
                else if (w.char_code == CH_BS)
                begin
                    if (model_col > 0)
                    begin
                        model_col--;
                        model_cells[model_row * COLS + model_col] = {model_blank, CH_SPACE};
                    end
                end
                else if (w.char_code >= CH_SPACE && w.char_code <= CH_TILDE)
                begin
                    model_cells[model_row * COLS + model_col] =
                        {w.back_color, w.fore_color, w.char_code};
                    model_col++;
                    if (model_col >= COLS)
                        r.scrolled = feed_line();
                end
            end
            REQ_SET:
            begin
                model_col = c;
                model_row = rw;
            end
            REQ_CLEAR:
            begin
                fill_screen();
                model_col = 0;
                model_row = 0;
            end
            default:
            begin
                cell_word = model_cells[rw * COLS + c];
                r.read_char = cell_word[7:0];
                r.read_attr = cell_word[15:8];
            end
        endcase
        r.cursor_col    = model_col[6:0];
        r.cursor_row    = model_row[4:0];
        r.cursor_offset = 11'(model_row * COLS + model_col);
        return r;
    endfunction

    function automatic tcw_req_t random_word();
        tcw_req_t w;
        int       pick;
        int       k;
        w.req_type   = REQ_PUT;
        w.char_code  = 8'($urandom_range(32, 126));
        w.fore_color = 4'($urandom);
        w.back_color = 4'($urandom);
        w.col_in     = 8'($urandom);
        w.row_in     = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 55)
        begin
            k = $urandom_range(0, 99);
            if (k >= 93)
                w.char_code = 8'($urandom_range(0, 255));
            else if (k >= 83)
                w.char_code = CH_BS;
            else if (k >= 78)
                w.char_code = CH_CR;
            else if (k >= 68)
                w.char_code = CH_LF;
        end
        else if (pick < 72)
        begin
            w.req_type = REQ_SET;
            if ($urandom_range(0, 1) == 0)
            begin
                w.col_in = 8'($urandom_range(60, COLS - 1));
                w.row_in = 8'($urandom_range(ROWS - 5, ROWS - 1));
            end
        end
        else if (pick < 75)
            w.req_type = REQ_CLEAR;
        else
        begin
            w.req_type = REQ_READ;
            if ($urandom_range(0, 1) == 0)
            begin
                w.col_in = 8'($urandom_range(0, COLS - 1));
                w.row_in = 8'(model_row);
            end
        end
        return w;
    endfunction

    task automatic send_word(input tcw_req_t w, input int gap, input bit typed,
                             input tcw_rsp_t fixed);
        tcw_rsp_t r;
        @(negedge clk);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req   <= w;
        do
            @(posedge clk);
        while (busy);
        r = console_apply(w);
        due_rsp_q.push_back(typed ? fixed : r);
    endtask

    task automatic hold_start();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic set_blank(input logic [7:0] color);
        hold_start();
        while (due_rsp_q.size() != 0)
            @(posedge clk);
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= color;
        @(negedge clk);
        cfg_we   <= 1'b0;
        model_blank = color;
    endtask

    always @(posedge clk)
    begin
        tcw_rsp_t want;
        if (rst_n && done)
        begin
            if (due_rsp_q.size() == 0)
                report_mismatch("unexpected word", 1, 0);
            else
            begin
                want = due_rsp_q.pop_front();
                if (rsp.cursor_col != want.cursor_col)
                    report_mismatch("cursor_col", rsp.cursor_col, want.cursor_col);
                if (rsp.cursor_row != want.cursor_row)
                    report_mismatch("cursor_row", rsp.cursor_row, want.cursor_row);
                if (rsp.cursor_offset != want.cursor_offset)
                    report_mismatch("cursor_offset", rsp.cursor_offset, want.cursor_offset);
                if (rsp.read_char != want.read_char)
                    report_mismatch("read_char", rsp.read_char, want.read_char);
                if (rsp.read_attr != want.read_attr)
                    report_mismatch("read_attr", rsp.read_attr, want.read_attr);
                if (rsp.scrolled != want.scrolled)
                    report_mismatch("scrolled", rsp.scrolled, want.scrolled);
            end
        end
    end

    initial
    begin
        logic [7:0] phase_blank [4];
        int         gap;
        tcw_rsp_t   none;
        err_count   = 0;
        none        = '0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        cfg_we      = 1'b0;
        cfg_data    = 8'h00;
        model_blank = RESET_BLANK;
        model_col   = 0;
        model_row   = 0;
        fill_screen();

        dir_table.push_back('{mk_req(REQ_READ, 0, 0, 0, 0, 0), 1, mk_rsp(0, 0, 0, 32, 7, 0)});
        dir_table.push_back('{mk_req(REQ_READ, 0, 0, 0, 255, 255), 1,
                              mk_rsp(0, 0, 0, 32, 7, 0)});
        dir_table.push_back('{mk_req(REQ_PUT, CH_BS, 0, 0, 0, 0), 1, mk_rsp(0, 0, 0, 0, 0, 0)});
        dir_table.push_back('{mk_req(REQ_PUT, 65, 15, 0, 0, 0), 1, mk_rsp(1, 0, 1, 0, 0, 0)});
        dir_table.push_back('{mk_req(REQ_READ, 0, 0, 0, 0, 0), 1,
                              mk_rsp(1, 0, 1, 65, 8'h0f, 0)});
        dir_table.push_back('{mk_req(REQ_PUT, CH_BS, 0, 0, 0, 0), 1, mk_rsp(0, 0, 0, 0, 0, 0)});
        dir_table.push_back('{mk_req(REQ_READ, 0, 0, 0, 0, 0), 1, mk_rsp(0, 0, 0, 32, 7, 0)});
        dir_table.push_back('{mk_req(REQ_PUT, 0, 15, 15, 0, 0), 1, mk_rsp(0, 0, 0, 0, 0, 0)});
        dir_table.push_back('{mk_req(REQ_PUT, 255, 15, 15, 0, 0), 1, mk_rsp(0, 0, 0, 0, 0, 0)});
        dir_table.push_back('{mk_req(REQ_PUT, 127, 3, 4, 0, 0), 0, none});
        dir_table.push_back('{mk_req(REQ_PUT, 31, 3, 4, 0, 0), 0, none});
        dir_table.push_back('{mk_req(REQ_PUT, 32, 0, 15, 0, 0), 0, none});
        dir_table.push_back('{mk_req(REQ_PUT, 126, 5, 10, 0, 0), 0, none});
        dir_table.push_back('{mk_req(REQ_PUT, CH_CR, 0, 0, 0, 0), 0, none});
        dir_table.push_back('{mk_req(REQ_PUT, CH_LF, 0, 0, 0, 0), 0, none});
        dir_table.push_back('{mk_req(REQ_SET, 0, 0, 0, 255, 255), 1,
                              mk_rsp(79, 24, 1999, 0, 0, 0)});
        dir_table.push_back('{mk_req(REQ_PUT, 126, 15, 15, 0, 0), 1,
                              mk_rsp(0, 24, 1920, 0, 0, 1)});
        dir_table.push_back('{mk_req(REQ_READ, 0, 0, 0, 79, 23), 1,
                              mk_rsp(0, 24, 1920, 126, 8'hff, 0)});
        dir_table.push_back('{mk_req(REQ_PUT, CH_LF, 0, 0, 0, 0), 1,
                              mk_rsp(0, 24, 1920, 0, 0, 1)});
        dir_table.push_back('{mk_req(REQ_READ, 0, 0, 0, 79, 22), 0, none});
        dir_table.push_back('{mk_req(REQ_READ, 0, 0, 0, 0, 24), 0, none});
        dir_table.push_back('{mk_req(REQ_SET, 0, 0, 0, 79, 0), 0, none});
        dir_table.push_back('{mk_req(REQ_PUT, 90, 9, 6, 0, 0), 0, none});
        dir_table.push_back('{mk_req(REQ_CLEAR, 0, 0, 0, 0, 0), 1, mk_rsp(0, 0, 0, 0, 0, 0)});
        dir_table.push_back('{mk_req(REQ_READ, 0, 0, 0, 40, 12), 0, none});

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_table[i])
            send_word(dir_table[i].word, $urandom_range(0, 15), dir_table[i].typed,
                      dir_table[i].want);

        phase_blank[0] = 8'hff;
        phase_blank[1] = 8'h00;
        phase_blank[2] = 8'($urandom);
        phase_blank[3] = 8'($urandom);
        for (int p = 0; p < 4; p++)
        begin
            set_blank(phase_blank[p]);
            send_word(mk_req(REQ_CLEAR, 0, 0, 0, 0, 0), 0, 1'b0, none);
            for (int n = 0; n < 38; n++)
            begin
                gap = ((n / 12) % 3 == 1) ? 0 : $urandom_range(0, 15);
                send_word(random_word(), gap, 1'b0, none);
            end
        end
        hold_start();

        while (due_rsp_q.size() != 0)
            @(posedge clk);
        repeat (2100) @(posedge clk);
        if (err_count == 0)
            $display("tb_text_console_writer OK");
        else
            $display("tb_text_console_writer NOT OK");
        $finish;
    end

endmodule
